FILE: hdl/aqp_pkg.sv
// Shared types, constants and helpers of the announce query parser.
package aqp_pkg;

	localparam int HASH_CHARS = 40;
	localparam int HASH_WORDS = 5;
	localparam int HASH_BITS = HASH_WORDS * 64;
	localparam int IDX_W = $clog2(HASH_CHARS);
	localparam int STG_W = $clog2(HASH_CHARS + 3);
	localparam int MAX_NUMBER_CHARS = 99;
	localparam int PORT_MAX = 65335;
	localparam int RESULTS = 2 + HASH_WORDS;
	localparam int RES_W = $clog2(RESULTS);

	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [1:0] {
		TOK_EMPTY,
		TOK_NAME,
		TOK_VALUE
	} tok_phase_t;

	typedef enum logic [1:0] {
		NUM_WS,
		NUM_SIGN,
		NUM_DIGITS,
		NUM_STOP
	} num_phase_t;

	typedef enum logic [1:0] {
		KIND_LEFT,
		KIND_PORT,
		KIND_HASH
	} kind_t;

	// Results of one query, handed from the parser to the emitter.
	typedef struct packed {
		logic [63:0]            left;
		logic signed [16:0]     port;
		logic [HASH_BITS-1:0]   hash;
	} snap_t;

	// Key names: 0 left, 1 hash key, 2 port.
	function automatic logic [3:0] key_len(input int k);
		case (k)
			0: key_len = 4'd4;
			1: key_len = 4'd9;
			default: key_len = 4'd4;
		endcase
	endfunction

	function automatic logic [7:0] key_char(input int k, input logic [3:0] i);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			0: begin
				case (i)
					4'd0: c = "l";
					4'd1: c = "e";
					4'd2: c = "f";
					4'd3: c = "t";
					default: c = 8'h00;
				endcase
			end
			1: begin
				case (i)
					4'd0: c = "i";
					4'd1: c = "n";
					4'd2: c = "f";
					4'd3: c = "o";
					4'd4: c = "_";
					4'd5: c = "h";
					4'd6: c = "a";
					4'd7: c = "s";
					default: c = "h";
				endcase
			end
			default: begin
				case (i)
					4'd0: c = "p";
					4'd1: c = "o";
					4'd2: c = "r";
					4'd3: c = "t";
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
	endfunction

endpackage

FILE: hdl/aqp_front.sv
// Parser front: one byte a cycle while accepted; builds left, port and hash text.
module aqp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     ch,
	input  logic           end_of_query,
	output logic           push,
	output aqp_pkg::snap_t snap
);
	import aqp_pkg::*;

	logic [7:0]        text_q [HASH_CHARS];
	logic [7:0]        stage_q [HASH_CHARS];
	logic [7:0]        text_d [HASH_CHARS];
	logic [STG_W-1:0]  stg_cnt_q;
	logic [1:0]        pct_q;
	logic              stop_q;
	tok_phase_t        tok_q;
	logic [2:0]        match_q;
	logic [3:0]        nlen_q;
	logic              terr_q;
	logic [6:0]        vlen_q;
	num_phase_t        nph_q;
	logic              neg_q;
	logic              bad_q;
	logic [63:0]       acc_q;
	logic [63:0]       left_q;
	logic signed [16:0] port_q;

	logic              tok_ok;
	logic [63:0]       nres;
	logic [31:0]       port_low;
	logic [63:0]       fin_left;
	logic signed [16:0] fin_port;
	logic [67:0]       acc_next;
	logic [67:0]       limit;
	logic [STG_W-1:0]  pct_idx;
	logic [STG_W-1:0]  stg_plus2;
	logic [STG_W-1:0]  stg_plus1;
	logic              is_digit;
	logic              val_char;

	// Finish of the current parameter
	always_comb begin
		tok_ok = (tok_q == TOK_VALUE) && !terr_q && (nlen_q != 4'd0) && (vlen_q != 7'd0);
		if ((vlen_q > 7'(MAX_NUMBER_CHARS)) || (vlen_q == 7'd127) || bad_q ||
				(nph_q == NUM_WS) || (nph_q == NUM_SIGN)) begin
			nres = '1;
		end else begin
			nres = neg_q ? (64'd0 - acc_q) : acc_q;
		end
		port_low = nres[31:0];
		fin_left = left_q;
		if (tok_ok && match_q[0] && (nlen_q == key_len(0))) begin
			fin_left = nres;
		end
		fin_port = port_q;
		if (tok_ok && match_q[2] && (nlen_q == key_len(2))) begin
			fin_port = (port_low[31] || (port_low > 32'(PORT_MAX))) ? '1 : port_low[16:0];
		end
		for (int i = 0; i < HASH_CHARS; i++) begin
			text_d[i] = (tok_ok && match_q[1] && (nlen_q == key_len(1)) &&
				(STG_W'(i) < stg_cnt_q)) ? stage_q[i] : text_q[i];
		end
	end

	// Snapshot pushed on the end marker
	always_comb begin
		push = accept && end_of_query;
		snap.left = fin_left;
		snap.port = fin_port;
		snap.hash = '0;
		for (int b = 0; b < HASH_WORDS * 8; b++) begin
			if (b < HASH_CHARS) begin
				snap.hash[b*8 +: 8] = text_d[b];
			end
		end
	end

	// Number and hash helpers; limit is 2^63 for a negative value, 2^63-1 otherwise
	always_comb begin
		is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		acc_next = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, ch[3:0] - CH_ZERO[3:0]};
		limit = neg_q ? {4'd0, 1'b1, 63'd0} : {4'd0, 1'b0, {63{1'b1}}};
		pct_idx = stg_cnt_q + STG_W'(2) - STG_W'(pct_q);
		stg_plus1 = stg_cnt_q + STG_W'(1);
		stg_plus2 = stg_cnt_q + STG_W'(2);
		val_char = accept && !end_of_query && (ch != CH_AMP) && (ch != CH_EQ) &&
			(tok_q == TOK_VALUE);
	end

	// Hash text staging
	always_ff @(posedge clk) begin
		if (val_char) begin
			if (pct_q != 2'd0) begin
				if (pct_idx < STG_W'(HASH_CHARS)) begin
					stage_q[pct_idx[IDX_W-1:0]] <= ch;
				end
			end else if (!stop_q && (stg_cnt_q < STG_W'(HASH_CHARS)) && (ch != CH_PCT)) begin
				stage_q[stg_cnt_q[IDX_W-1:0]] <= hex_digit(ch[7:4]);
				if (stg_plus1 < STG_W'(HASH_CHARS)) begin
					stage_q[stg_plus1[IDX_W-1:0]] <= hex_digit(ch[3:0]);
				end
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_CHARS; i++) begin
				text_q[i] <= '0;
			end
			stg_cnt_q <= '0;
			pct_q <= '0;
			stop_q <= 1'b0;
			tok_q <= TOK_EMPTY;
			match_q <= 3'b111;
			nlen_q <= '0;
			terr_q <= 1'b0;
			vlen_q <= '0;
			nph_q <= NUM_WS;
			neg_q <= 1'b0;
			bad_q <= 1'b0;
			acc_q <= '0;
			left_q <= '1;
			port_q <= '1;
		end else if (accept) begin
			if (end_of_query || (ch == CH_AMP)) begin
				stg_cnt_q <= '0;
				pct_q <= '0;
				stop_q <= 1'b0;
				tok_q <= TOK_EMPTY;
				match_q <= 3'b111;
				nlen_q <= '0;
				terr_q <= 1'b0;
				vlen_q <= '0;
				nph_q <= NUM_WS;
				neg_q <= 1'b0;
				bad_q <= 1'b0;
				acc_q <= '0;
				if (end_of_query) begin
					for (int i = 0; i < HASH_CHARS; i++) begin
						text_q[i] <= '0;
					end
					left_q <= '1;
					port_q <= '1;
				end else begin
					text_q <= text_d;
					left_q <= fin_left;
					port_q <= fin_port;
				end
			end else if (ch == CH_EQ) begin
				if (tok_q == TOK_VALUE) begin
					terr_q <= 1'b1;
				end
				tok_q <= TOK_VALUE;
			end else if (tok_q != TOK_VALUE) begin
				// name character: narrow the key candidates
				for (int w = 0; w < 3; w++) begin
					if ((nlen_q >= key_len(w)) ||
							(key_char(w, (nlen_q < 4'd9) ? nlen_q : 4'd8) != ch)) begin
						match_q[w] <= 1'b0;
					end
				end
				if (nlen_q != 4'd15) begin
					nlen_q <= nlen_q + 4'd1;
				end
				tok_q <= TOK_NAME;
			end else begin
				// value character: integer parse
				if (!bad_q && (nph_q != NUM_STOP)) begin
					if (ch == 8'h00) begin
						if ((nph_q == NUM_DIGITS) || (vlen_q == 7'd0)) begin
							nph_q <= NUM_STOP;
						end else begin
							bad_q <= 1'b1;
						end
					end else if ((nph_q == NUM_WS) &&
							((ch == CH_SPACE) || ((ch >= 8'h09) && (ch <= 8'h0D)))) begin
						nph_q <= NUM_WS;
					end else if ((nph_q == NUM_WS) && ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
						neg_q <= (ch == CH_MINUS);
						nph_q <= NUM_SIGN;
					end else if (!is_digit) begin
						bad_q <= 1'b1;
					end else begin
						if (acc_next > limit) begin
							bad_q <= 1'b1;
						end else begin
							acc_q <= acc_next[63:0];
						end
						nph_q <= NUM_DIGITS;
					end
				end
				// value character: hash text count
				if (pct_q != 2'd0) begin
					pct_q <= pct_q - 2'd1;
					if (pct_q == 2'd1) begin
						if (stg_plus2 >= STG_W'(HASH_CHARS)) begin
							stg_cnt_q <= STG_W'(HASH_CHARS);
							stop_q <= 1'b1;
						end else begin
							stg_cnt_q <= stg_plus2;
						end
					end
				end else if (!stop_q && (stg_cnt_q < STG_W'(HASH_CHARS))) begin
					if (ch == CH_PCT) begin
						pct_q <= 2'd2;
					end else begin
						if (stg_plus2 >= STG_W'(HASH_CHARS)) begin
							stg_cnt_q <= STG_W'(HASH_CHARS);
							stop_q <= 1'b1;
						end else begin
							stg_cnt_q <= stg_plus2;
						end
					end
				end
				if (vlen_q != 7'd127) begin
					vlen_q <= vlen_q + 7'd1;
				end
			end
		end
	end

endmodule

FILE: hdl/aqp_queue.sv
// Two-entry queue of finished query snapshots between parser and emitter.
module aqp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  aqp_pkg::snap_t wr_data,
	input  logic           pop,
	output aqp_pkg::snap_t rd_data,
	output logic           empty,
	output logic           full
);
	import aqp_pkg::*;

	snap_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign empty = (count_q == 2'd0);
	assign full = (count_q == 2'd2);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: hdl/aqp_back.sv
// Result emitter: turns each snapshot into left, port and hash word beats.
module aqp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  aqp_pkg::snap_t   rd_data,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output aqp_pkg::kind_t   out_kind,
	output logic [2:0]       out_word,
	output logic [63:0]      out_value,
	output logic             out_last
);
	import aqp_pkg::*;

	logic [RES_W-1:0] idx_q;
	logic             load;
	logic [RES_W-1:0] widx;

	assign load = !empty && (!out_valid || out_ready);
	assign pop = load && (idx_q == RES_W'(RESULTS - 1));
	assign widx = idx_q - RES_W'(2);

	// Beat counter within a query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= pop ? '0 : idx_q + RES_W'(1);
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk) begin
		if (load) begin
			out_last <= (idx_q == RES_W'(RESULTS - 1));
			case (idx_q)
				RES_W'(0): begin
					out_kind <= KIND_LEFT;
					out_word <= '0;
					out_value <= rd_data.left;
				end
				RES_W'(1): begin
					out_kind <= KIND_PORT;
					out_word <= '0;
					out_value <= 64'(rd_data.port);
				end
				default: begin
					out_kind <= KIND_HASH;
					out_word <= 3'(widx);
					out_value <= rd_data.hash[widx*64 +: 64];
				end
			endcase
		end
	end

endmodule

FILE: hdl/announce_query_parser_unit.sv
// The end-of-query beat queues its snapshot; the emitter loads the first result beat into its
// output register. One query byte is taken per cycle while s_tready is high; each query then
// yields 7 result beats, one a cycle while m_tready is high, set by this single output register.
// A two-snapshot queue decouples parser and emitter; while both entries are held s_tready is
// low, so queries shorter than 7 beats stall the input until the emitter frees an entry.
// Reset (arst_n low, asynchronous): parser cleared, left/port -1, hash zero, queue/output empty.
module announce_query_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	input  logic        s_tlast,  // end_of_query
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [2:0] word_index, [66:3] value, rest zero
	output logic [1:0]  m_tuser,  // [1:0] kind
	output logic        m_tlast   // last
);
	import aqp_pkg::*;

	logic   accept;
	logic   push;
	logic   pop;
	logic   empty;
	logic   full;
	snap_t  wr_snap;
	snap_t  rd_snap;
	kind_t  kind;
	logic [2:0]  word_index;
	logic [63:0] value;

	assign s_tready = !full;
	assign accept = s_tvalid && s_tready;

	aqp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.ch           (s_tdata),
		.end_of_query (s_tlast),
		.push         (push),
		.snap         (wr_snap)
	);

	aqp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_snap),
		.pop     (pop),
		.rd_data (rd_snap),
		.empty   (empty),
		.full    (full)
	);

	aqp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_data   (rd_snap),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (kind),
		.out_word  (word_index),
		.out_value (value),
		.out_last  (m_tlast)
	);

	// Pack the result beat
	assign m_tdata = {5'd0, value, word_index};
	assign m_tuser = kind;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the announce query parser: directed queries, then random queries.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import aqp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	announce_query_parser_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	typedef struct {
		kind_t       kind;
		logic [2:0]  widx;
		logic [63:0] value;
		logic        last;
	} beat_t;

	typedef struct {
		logic [7:0] ch;
		logic       eoq;
	} char_t;

	beat_t result_q[$];
	char_t drive_q[$];
	int    errors;
	int    dir_errors;
	int    send_idle_pct;
	int    recv_stall_pct;
	bit    hold_recv;
	int    hold_cycles;

	// predictor state
	logic [7:0]  p_text[40];
	logic [7:0]  p_stage[40];
	int          p_scount;
	int          p_pct;
	bit          p_stopped;
	tok_phase_t  p_tok;
	logic [2:0]  p_match;
	int          p_nlen;
	bit          p_terr;
	int          p_vlen;
	num_phase_t  p_num;
	bit          p_neg;
	bit          p_bad;
	logic [63:0] p_acc;
	logic [63:0] p_left;
	logic [63:0] p_port;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Key text built from the package key tables
	function automatic string key_str(int k);
		string s;
		s = "";
		for (int i = 0; i < int'(key_len(k)); i++) s = {s, string'(key_char(k, 4'(i)))};
		return s;
	endfunction

	function automatic logic [7:0] hexc(logic [3:0] n);
		return (n < 10) ? 8'h30 + n : 8'h57 + n;
	endfunction

	task automatic clear_param();
		p_scount = 0; p_pct = 0; p_stopped = 0; p_tok = TOK_EMPTY; p_match = 3'b111;
		p_nlen = 0; p_terr = 0; p_vlen = 0; p_num = NUM_WS; p_neg = 0; p_bad = 0;
		p_acc = '0;
	endtask

	task automatic clear_query();
		foreach (p_text[i]) p_text[i] = 8'h00;
		clear_param();
		p_left = '1;
		p_port = '1;
	endtask

	function automatic logic [63:0] parsed_number();
		if (p_vlen > MAX_NUMBER_CHARS || p_vlen >= 127) return '1;
		if (p_bad || p_num == NUM_WS || p_num == NUM_SIGN) return '1;
		return p_neg ? 64'd0 - p_acc : p_acc;
	endfunction

	task automatic close_param();
		logic [63:0] num;
		logic [31:0] low;
		string       kn;
		if (p_tok == TOK_VALUE && !p_terr && p_nlen != 0 && p_vlen != 0) begin
			for (int k = 0; k < 3; k++) begin
				kn = key_str(k);
				if (!p_match[k] || p_nlen != kn.len()) continue;
				if (k == 0) p_left = parsed_number();
				else if (k == 2) begin
					num = parsed_number();
					low = num[31:0];
					p_port = (low[31] || low > PORT_MAX) ? '1 : {32'd0, low};
				end else
					for (int i = 0; i < p_scount; i++) p_text[i] = p_stage[i];
			end
		end
		clear_param();
	endtask

	task automatic stage_step();
		p_scount += 2;
		if (p_scount >= 40) begin
			p_scount = 40;
			p_stopped = 1;
		end
	endtask

	task automatic hash_byte(logic [7:0] c);
		int idx;
		if (p_pct != 0) begin
			idx = p_scount + 2 - p_pct;
			if (idx < 40) p_stage[idx] = c;
			p_pct--;
			if (p_pct == 0) stage_step();
			return;
		end
		if (p_stopped || p_scount >= 40) return;
		if (c == CH_PCT) begin
			p_pct = 2;
			return;
		end
		p_stage[p_scount] = hexc(c[7:4]);
		if (p_scount + 1 < 40) p_stage[p_scount + 1] = hexc(c[3:0]);
		stage_step();
	endtask

	task automatic number_byte(logic [7:0] c);
		logic [63:0] lim;
		logic [63:0] d;
		if (p_bad || p_num == NUM_STOP) return;
		if (c == 0) begin
			if (p_num == NUM_DIGITS || p_vlen == 0) p_num = NUM_STOP;
			else p_bad = 1;
			return;
		end
		if (p_num == NUM_WS && (c == CH_SPACE || (c >= 9 && c <= 13))) return;
		if (p_num == NUM_WS && (c == CH_PLUS || c == CH_MINUS)) begin
			p_neg = (c == CH_MINUS);
			p_num = NUM_SIGN;
			return;
		end
		if (c < CH_ZERO || c > CH_NINE) begin
			p_bad = 1;
			return;
		end
		d = c - CH_ZERO;
		lim = p_neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
		if (p_acc > (lim - d) / 10) p_bad = 1;
		else p_acc = p_acc * 10 + d;
		p_num = NUM_DIGITS;
	endtask

	// Advance the predictor by one accepted beat; push results on end of query.
	task automatic predict_query_byte(char_t it);
		beat_t       b;
		logic [63:0] w;
		string       kn;
		if (!it.eoq) begin
			if (it.ch == CH_AMP) close_param();
			else if (it.ch == CH_EQ) begin
				if (p_tok == TOK_VALUE) p_terr = 1;
				p_tok = TOK_VALUE;
			end else if (p_tok != TOK_VALUE) begin
				for (int k = 0; k < 3; k++) begin
					kn = key_str(k);
					if (p_nlen >= kn.len() || kn[p_nlen] != it.ch) p_match[k] = 1'b0;
				end
				if (p_nlen < 15) p_nlen++;
				p_tok = TOK_NAME;
			end else begin
				number_byte(it.ch);
				hash_byte(it.ch);
				if (p_vlen < 127) p_vlen++;
			end
			return;
		end
		close_param();
		b.kind = KIND_LEFT; b.widx = 3'd0; b.value = p_left; b.last = 0;
		result_q.push_back(b);
		b.kind = KIND_PORT; b.value = p_port;
		result_q.push_back(b);
		for (int wi = 0; wi < HASH_WORDS; wi++) begin
			for (int j = 0; j < 8; j++) w[8*j +: 8] = p_text[wi*8 + j];
			b.kind = KIND_HASH; b.widx = 3'(wi); b.value = w; b.last = (wi == HASH_WORDS - 1);
			result_q.push_back(b);
		end
		clear_query();
	endtask

	// Output monitor and checker
	always @(posedge clk) begin
		beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat kind=%0d", m_tuser);
			end else begin
				e = result_q.pop_front();
				if (m_tuser !== e.kind || m_tdata[2:0] !== e.widx || m_tdata[66:3] !== e.value
						|| m_tdata[71:67] !== 5'd0 || m_tlast !== e.last) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp kind=%0d idx=%0d val=%h last=%b ",
							"got kind=%0d idx=%0d val=%h last=%b"},
							e.kind, e.widx, e.value, e.last, m_tuser, m_tdata[2:0],
							m_tdata[66:3], m_tlast);
				end
			end
		end
	end

	// Receiver ready, with random stalls and a long hold-off
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else if (hold_recv) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Sender: takes beats from drive_q, idles at random
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_query_byte('{ch: s_tdata, eoq: s_tlast});
				void'(drive_q.pop_front());
			end
			if ((!s_tvalid || s_tready)) begin
				if (drive_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= drive_q[0].ch;
					s_tlast <= drive_q[0].eoq;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++) drive_q.push_back('{ch: s[i], eoq: 1'b0});
	endtask

	task automatic put_end();
		drive_q.push_back('{ch: 8'h00, eoq: 1'b1});
	endtask

	task automatic wait_drained();
		while (drive_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic string rand_digits(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'(8'h30 + $urandom_range(9)))};
		return s;
	endfunction

	// One random value for a number parameter
	function automatic string rand_number();
		string s;
		s = "";
		case ($urandom_range(9))
			0: s = " \t";
			1: s = "+";
			2: s = "-";
			default: ;
		endcase
		s = {s, rand_digits($urandom_range(1, 5) == 5 ? $urandom_range(15, 22)
			: $urandom_range(1, 6))};
		if ($urandom_range(9) == 0) s = {s, "x"};
		return s;
	endfunction

	function automatic string rand_bytes(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
		return s;
	endfunction

	// One random query, mostly well formed
	task automatic put_rand_query();
		int np;
		np = $urandom_range(1, 2);
		for (int i = 0; i < np; i++) begin
			if (i != 0) put_str("&");
			case ($urandom_range(7))
				0, 1: put_str({"left=", rand_number()});
				2, 3: put_str({"port=", $urandom_range(3) == 0 ? rand_number()
					: $sformatf("%0d", $urandom_range(70000))});
				4, 5: begin
					put_str({key_str(1), "="});
					for (int j = $urandom_range(1, 12); j > 0; j--)
						if ($urandom_range(4) == 0) put_str({"%", rand_bytes(2)});
						else drive_q.push_back('{ch: 8'($urandom_range(255)), eoq: 1'b0});
				end
				6: put_str({rand_bytes($urandom_range(0, 4)), "=", rand_bytes($urandom_range(0, 3))});
				default: put_str({key_str($urandom_range(2)), "==", rand_digits(2)});
			endcase
		end
		put_end();
	endtask

	typedef struct {
		bit          hkey;
		string       q;
		bit          check_left;
		logic [63:0] left;
	} dir_row_t;

	// hkey rows start with the hash key and '='
	dir_row_t dir_rows[] = '{
		'{0, "",                                 1, 64'hFFFFFFFFFFFFFFFF},
		'{0, "left=9223372036854775807",          1, 64'h7FFFFFFFFFFFFFFF},
		'{0, "left=-9223372036854775808",         1, 64'h8000000000000000},
		'{0, "left=9223372036854775808",          1, 64'hFFFFFFFFFFFFFFFF},
		'{0, "left= \t+42&port=65335",            1, 64'd42},
		'{0, "port=65336&left=-",                 1, 64'hFFFFFFFFFFFFFFFF},
		'{0, "left=12x&=5&left&&port==1",         1, 64'hFFFFFFFFFFFFFFFF},
		'{0, "left=7&left=8&lefta=9",             1, 64'd8},
		'{1, "%41%42\xff&port=4294967297",        0, 0},
		'{1, "%4",                                0, 0},
		'{1, "abcdefghijklmnopqrstu%ZZ",          0, 0},
		'{1, "&port=-1",                          0, 0}
	};

	function automatic string row_text(int r);
		return dir_rows[r].hkey ? {key_str(1), "=", dir_rows[r].q} : dir_rows[r].q;
	endfunction

	initial begin
		logic [63:0] got_left;
		string       t;
		errors = 0;
		dir_errors = 0;
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		clear_query();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed queries; left amount checked literally where obvious
		foreach (dir_rows[r]) begin
			put_str(row_text(r));
			put_end();
			if (dir_rows[r].check_left) begin
				wait_drained();
			end
		end
		wait_drained();
		foreach (dir_rows[r]) begin
			clear_query();
			t = row_text(r);
			for (int i = 0; i < t.len(); i++) predict_query_byte('{ch: t[i], eoq: 1'b0});
			close_param();
			got_left = p_left;
			if (dir_rows[r].check_left && got_left !== dir_rows[r].left) begin
				dir_errors++;
				if (dir_errors <= 10) $display("directed row %0d: left exp %h pred %h", r,
					dir_rows[r].left, got_left);
			end
		end
		clear_query();
		// zero byte inside numbers
		put_str("left=");
		drive_q.push_back('{ch: 8'h00, eoq: 1'b0});
		put_str("9&port=12");
		drive_q.push_back('{ch: 8'h00, eoq: 1'b0});
		put_str("x");
		put_end();
		wait_drained();

		// Random phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < 2; n++) put_rand_query();
			if (ph == 0) begin
				// long receiver hold-off while queries keep coming
				fork
					begin
						hold_recv <= 1'b1;
						for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge clk);
						hold_recv <= 1'b0;
					end
				join_none
				for (int n = 0; n < 4; n++) begin
					put_str("left=1");
					put_end();
				end
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && dir_errors == 0 && result_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

FILE: announce_query_parser_unit.f
hdl/aqp_pkg.sv
hdl/aqp_front.sv
hdl/aqp_queue.sv
hdl/aqp_back.sv
hdl/announce_query_parser_unit.sv
dv/tb_top.sv
